### hw/rtl/rrq_pkg.sv
// Shared types, constants and pointer helpers for the ring run queue.
package rrq_pkg;

   localparam int CAPACITY     = 1024;
   localparam int HANDLE_WIDTH = 32;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int BLEN_W   = 11;
   localparam int OCCF_W   = 11;

   localparam int PTR_W  = $clog2(2 * CAPACITY);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int OCC_W  = $clog2(CAPACITY + 1);
   localparam int SUM_W  = OCC_W + BLEN_W;
   localparam int ENTRY_W = HANDLE_WIDTH + 1;

   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_BATCH = 2'd1;
   localparam logic [OP_W-1:0] OP_POP   = 2'd2;
   localparam logic [OP_W-1:0] OP_STEAL = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [HANDLE_WIDTH-1:0] entity;
      logic                    not_stealable;
      logic [BLEN_W-1:0]       batch_len;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [HANDLE_WIDTH-1:0] entity_out;
      logic [OCCF_W-1:0]       occupancy;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(2 * CAPACITY - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] s;
      s = (p >= PTR_W'(CAPACITY)) ? p - PTR_W'(CAPACITY) : p;
      return s[IDX_W-1:0];
   endfunction

   function automatic logic [OCC_W-1:0] occ_of(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
      logic [PTR_W:0] d;
      if (wp >= rp) begin
         d = {1'b0, wp} - {1'b0, rp};
      end else begin
         d = {1'b0, wp} + (PTR_W + 1)'(2 * CAPACITY) - {1'b0, rp};
      end
      return d[OCC_W-1:0];
   endfunction

endpackage

### hw/rtl/rrq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module rrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rrq_ctrl.sv
// Controller FSM: takes one item, then commits it once the output slot is free.
module rrq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrq_pkg::dp_status_type dp_status,
   output rrq_pkg::ctl_cmd_type  cmd
);
   import rrq_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // RAM read data for the oldest entry is valid here
            if (dp_status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/rrq_dp.sv
// Datapath: pointers, batch tracking, entry RAM and output register.
module rrq_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  rrq_pkg::ctl_cmd_type cmd,
   output rrq_pkg::dp_status_type dp_status,
   input  rrq_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rrq_pkg::rsp_type     rsp_data
);
   import rrq_pkg::*;

   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [BLEN_W-1:0] brem_ff, brem_in;
   logic              bacc_ff, bacc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   req_type           req_ff;

   logic [OCC_W-1:0]   occ;
   logic [BLEN_W-1:0]  blen_eff;
   logic [SUM_W-1:0]   need;
   logic               is_full;
   logic               do_store;
   logic               do_take;
   logic [OCC_W-1:0]   occ_after;
   logic [ENTRY_W-1:0] rd_entry;

   assign occ     = occ_of(wp_ff, rp_ff);
   assign is_full = (occ >= OCC_W'(CAPACITY));
   assign blen_eff = (req_ff.batch_len == '0) ? BLEN_W'(1) : req_ff.batch_len;
   assign need    = SUM_W'(occ) + SUM_W'(blen_eff);

   always_comb begin
      brem_in   = brem_ff;
      bacc_in   = bacc_ff;
      do_store  = 1'b0;
      do_take   = 1'b0;
      rsp_in    = rsp_ff;
      rsp_in.status     = ST_DONE;
      rsp_in.entity_out = '0;
      if (req_ff.op != OP_BATCH) begin
         brem_in = '0;
         bacc_in = 1'b0;
      end
      case (req_ff.op)
         OP_PUSH: begin
            do_store      = !is_full;
            rsp_in.status = is_full ? ST_FULL : ST_DONE;
         end
         OP_BATCH: begin
            if (brem_ff == '0) begin
               bacc_in = (need < SUM_W'(CAPACITY));
               brem_in = blen_eff;
            end
            brem_in       = brem_in - BLEN_W'(1);
            do_store      = bacc_in && !is_full;
            rsp_in.status = do_store ? ST_DONE : ST_FULL;
            if (brem_in == '0) begin
               bacc_in = 1'b0;
            end
         end
         default: begin
            // pop or steal
            if (occ == '0) begin
               rsp_in.status = ST_EMPTY;
            end else if (req_ff.op == OP_STEAL && rd_entry[HANDLE_WIDTH]) begin
               rsp_in.status = ST_BLOCKED;
            end else begin
               do_take           = 1'b1;
               rsp_in.entity_out = rd_entry[HANDLE_WIDTH-1:0];
            end
         end
      endcase
      occ_after = occ;
      if (do_store) begin
         occ_after = occ + OCC_W'(1);
      end else if (do_take) begin
         occ_after = occ - OCC_W'(1);
      end
      rsp_in.occupancy = OCCF_W'(occ_after);

      wp_in = (cmd.commit && do_store) ? next_ptr(wp_ff) : wp_ff;
      rp_in = (cmd.commit && do_take) ? next_ptr(rp_ff) : rp_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign dp_status.out_free = !rsp_valid_ff || rsp_ready;

   rrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && do_store),
      .wr_addr (slot_of(wp_ff)),
      .wr_data ({req_ff.not_stealable, req_ff.entity}),
      .rd_addr (slot_of(rp_ff)),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         brem_ff      <= '0;
         bacc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) begin
            brem_ff <= brem_in;
            bacc_ff <= bacc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/ring_run_queue_with_steal.sv
// Top level of the ring run queue with steal.
// Bounded ring queue of task handles, each stored with a not-stealable flag.
// Ops: push, batch push element (all-or-nothing batch, length on the first
// element, accepted only if occupancy plus length stays below capacity; any
// other op ends a pending batch), pop (oldest entry) and steal (oldest entry
// unless its flag is set, then status blocked). Every item yields exactly one
// result transfer carrying status, removed handle and occupancy after the item.
// Timing: the registered RAM read of the oldest entry happens at the accepting
// edge and the item commits once the output register is free, after which its
// result is offered. req_ready is high only while the controller is idle, so
// the block takes no new item until the previous one has committed. The result
// sits in an output register, so a new item is taken while a finished result
// still waits; a commit stalls only when that register is still full. Entry
// storage is a 1024 x 33 RAM with no reset; no clearing pass is needed since
// only occupied entries are read.
module ring_run_queue_with_steal (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rrq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrq_pkg::rsp_type rsp_data
);
   import rrq_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   // sequencing: accept, wait on RAM read, commit into output register
   rrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // pointers, batch state, entry RAM, result register
   rrq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_status (dp_status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/rrq_checker.sv
// Port-level checker for the ring run queue, bound to the top level.
module rrq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input rrq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rrq_pkg::rsp_type rsp_data
);
   import rrq_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: no transfer in the cycle after a transfer
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while previous item in work");

   // only a done result returns a handle
   a_entity_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_DONE |-> rsp_data.entity_out == '0)
      else $error("handle returned on non-done status");

   // empty status implies zero occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.occupancy == '0)
      else $error("empty status with nonzero occupancy");

   // occupancy within capacity
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.occupancy <= OCCF_W'(CAPACITY))
      else $error("occupancy above capacity");

endmodule

bind ring_run_queue_with_steal rrq_checker u_rrq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
